@@ design/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// SPI EEPROM master package
// Shared types, command codes and the frame program table.
// ----------------------------------------------------------------------------
package sem_pkg;

    typedef enum logic [1:0] {
        OP_READ_BYTE    = 2'd0,
        OP_WRITE_BYTE   = 2'd1,
        OP_READ_STATUS  = 2'd2,
        OP_WRITE_STATUS = 2'd3
    } sem_op_t;

    typedef enum logic [2:0] {
        F_END       = 3'd0,
        F_WREN      = 3'd1,
        F_WRSR_PRE  = 3'd2,
        F_WRSR_DATA = 3'd3,
        F_POLL      = 3'd4,
        F_RDSR      = 3'd5,
        F_READ      = 3'd6,
        F_WRITE     = 3'd7
    } sem_frame_t;

    typedef enum logic [1:0] {
        CFG_HALF_PERIOD     = 2'd0,
        CFG_POLL_LIMIT      = 2'd1,
        CFG_STATUS_PREAMBLE = 2'd2,
        CFG_UNUSED          = 2'd3
    } sem_cfg_idx_t;

    localparam logic [7:0] CMD_WRSR  = 8'h01;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WREN  = 8'h06;

    localparam logic [3:0] SEQ_IDLE = 4'd15;

    localparam logic [15:0] HALF_PERIOD_RST     = 16'd280;
    localparam logic [7:0]  POLL_LIMIT_RST      = 8'd255;
    localparam logic [7:0]  STATUS_PREAMBLE_RST = 8'h80;

    localparam int RX_BITS = 8;

    typedef struct packed {
        logic [15:0] half_period;
        logic [7:0]  poll_limit;
        logic [7:0]  status_preamble;
    } sem_cfg_t;

    typedef struct packed {
        logic       timed_out;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       cs_n;
        logic       mosi;
        logic       sclk;
    } sem_result_t;

    function automatic sem_frame_t prog_kind(input sem_op_t op, input logic [2:0] step);
        sem_frame_t kind;
        kind = F_END;
        unique case (op)
            OP_READ_BYTE:
            begin
                if (step == 3'd0) kind = F_READ;
            end
            OP_READ_STATUS:
            begin
                if (step == 3'd0) kind = F_RDSR;
            end
            OP_WRITE_STATUS:
            begin
                unique case (step)
                    3'd0:    kind = F_WREN;
                    3'd1:    kind = F_WRSR_DATA;
                    3'd2:    kind = F_POLL;
                    default: kind = F_END;
                endcase
            end
            OP_WRITE_BYTE:
            begin
                unique case (step)
                    3'd0:    kind = F_WREN;
                    3'd1:    kind = F_WREN;
                    3'd2:    kind = F_WRSR_PRE;
                    3'd3:    kind = F_POLL;
                    3'd4:    kind = F_WREN;
                    3'd5:    kind = F_WRITE;
                    3'd6:    kind = F_POLL;
                    default: kind = F_END;
                endcase
            end
            default: kind = F_END;
        endcase
        return kind;
    endfunction

    function automatic logic frame_has_rx(input sem_frame_t kind);
        return (kind == F_POLL) || (kind == F_RDSR) || (kind == F_READ);
    endfunction

endpackage

@@ design/sem_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// SPI EEPROM master configuration registers
// Holds half period, poll limit and status preamble; writes by index.
// ----------------------------------------------------------------------------
module sem_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output sem_pkg::sem_cfg_t cfg
);
    import sem_pkg::*;

    sem_cfg_t cfg_reg;
    sem_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (sem_cfg_idx_t'(cfg_index))
                CFG_HALF_PERIOD:     cfg_next.half_period     = cfg_data;
                CFG_POLL_LIMIT:      cfg_next.poll_limit      = cfg_data[7:0];
                CFG_STATUS_PREAMBLE: cfg_next.status_preamble = cfg_data[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period     <= HALF_PERIOD_RST;
            cfg_reg.poll_limit      <= POLL_LIMIT_RST;
            cfg_reg.status_preamble <= STATUS_PREAMBLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/sem_engine.sv @@
// ----------------------------------------------------------------------------
// SPI EEPROM master tick engine
// Advances the frame sequencer, bit shifter and pin levels by one tick.
// ----------------------------------------------------------------------------
module sem_engine #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  sem_pkg::sem_cfg_t    cfg,
    input  logic                 start_req,
    input  logic [1:0]           opcode,
    input  logic [15:0]          address,
    input  logic [7:0]           write_data,
    input  logic                 miso,
    output sem_pkg::sem_result_t result
);
    import sem_pkg::*;

    localparam int FRAME_W = 16 + ADDR_BITS;
    localparam int BIT_W   = $clog2(FRAME_W + 1);
    localparam int LOAD_W  = BIT_W + FRAME_W;

    logic [3:0]           step_reg,      step_next;
    logic [BIT_W-1:0]     bit_cnt_reg,   bit_cnt_next;
    logic [FRAME_W-1:0]   shift_reg,     shift_next;
    logic [7:0]           in_shift_reg,  in_shift_next;
    logic [15:0]          hp_cnt_reg,    hp_cnt_next;
    logic [7:0]           poll_cnt_reg,  poll_cnt_next;
    sem_op_t              op_reg,        op_next;
    logic [ADDR_BITS-1:0] addr_reg,      addr_next;
    logic [7:0]           data_reg,      data_next;
    logic                 sclk_reg,      sclk_next;
    logic                 mosi_reg,      mosi_next;
    logic                 cs_reg,        cs_next;
    logic [7:0]           rdata_reg,     rdata_next;
    logic                 tout_reg,      tout_next;

    logic [ADDR_BITS+15:0] addr_wide;
    logic [ADDR_BITS-1:0]  addr_in;
    logic [15:0]           limit;
    logic [15:0]           hp_inc;
    sem_frame_t            kind;
    sem_frame_t            next_kind;
    logic [BIT_W-1:0]      rx;
    logic [FRAME_W-1:0]    shifted;
    logic [BIT_W-1:0]      bc_dec;
    logic [2:0]            step_inc;
    logic [LOAD_W-1:0]     load;
    logic                  done;

    function automatic logic [LOAD_W-1:0] frame_load(
        input sem_frame_t           k,
        input logic [ADDR_BITS-1:0] a,
        input logic [7:0]           d,
        input logic [7:0]           pre
    );
        logic [FRAME_W-1:0] value;
        logic [BIT_W-1:0]   bits;
        unique case (k)
            F_WRSR_PRE:
            begin
                value = {CMD_WRSR, pre, {ADDR_BITS{1'b0}}};
                bits  = BIT_W'(16);
            end
            F_WRSR_DATA:
            begin
                value = {CMD_WRSR, d, {ADDR_BITS{1'b0}}};
                bits  = BIT_W'(16);
            end
            F_POLL, F_RDSR:
            begin
                value = {CMD_RDSR, 8'h00, {ADDR_BITS{1'b0}}};
                bits  = BIT_W'(16);
            end
            F_READ:
            begin
                value = {CMD_READ, a, 8'h00};
                bits  = BIT_W'(FRAME_W);
            end
            F_WRITE:
            begin
                value = {CMD_WRITE, a, d};
                bits  = BIT_W'(FRAME_W);
            end
            default:
            begin
                value = {CMD_WREN, {(FRAME_W-8){1'b0}}};
                bits  = BIT_W'(8);
            end
        endcase
        return {bits, value};
    endfunction

    assign addr_wide = {{ADDR_BITS{1'b0}}, address};
    assign addr_in   = addr_wide[ADDR_BITS-1:0];
    assign limit     = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
    assign hp_inc    = hp_cnt_reg + 16'd1;
    assign kind      = prog_kind(op_reg, step_reg[2:0]);
    assign rx        = frame_has_rx(kind) ? BIT_W'(RX_BITS) : '0;
    assign shifted   = {shift_reg[FRAME_W-2:0], 1'b0};
    assign bc_dec    = (bit_cnt_reg != '0) ? bit_cnt_reg - BIT_W'(1) : '0;
    assign step_inc  = step_reg[2:0] + 3'd1;

    always_comb
    begin
        step_next     = step_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        in_shift_next = in_shift_reg;
        hp_cnt_next   = hp_cnt_reg;
        poll_cnt_next = poll_cnt_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        data_next     = data_reg;
        sclk_next     = sclk_reg;
        mosi_next     = mosi_reg;
        cs_next       = cs_reg;
        rdata_next    = rdata_reg;
        tout_next     = tout_reg;
        next_kind     = F_END;
        load          = '0;
        done          = 1'b0;

        if (step_reg == SEQ_IDLE)
        begin
            if (start_req)
            begin
                op_next       = sem_op_t'(opcode);
                addr_next     = addr_in;
                data_next     = write_data;
                tout_next     = 1'b0;
                poll_cnt_next = '0;
                step_next     = 4'd0;
                next_kind     = prog_kind(sem_op_t'(opcode), 3'd0);
                load          = frame_load(next_kind, addr_in, write_data,
                                           cfg.status_preamble);
                bit_cnt_next  = load[LOAD_W-1:FRAME_W];
                shift_next    = load[FRAME_W-1:0];
                in_shift_next = '0;
                hp_cnt_next   = '0;
            end
        end
        else if (hp_inc >= limit)
        begin
            hp_cnt_next = '0;
            if (cs_reg)
            begin
                cs_next   = 1'b0;
                sclk_next = 1'b0;
                if (bit_cnt_reg > rx) mosi_next = shift_reg[FRAME_W-1];
            end
            else if (!sclk_reg)
            begin
                if (bit_cnt_reg <= rx) in_shift_next = {in_shift_reg[6:0], miso};
                sclk_next = 1'b1;
            end
            else
            begin
                shift_next   = shifted;
                bit_cnt_next = bc_dec;
                sclk_next    = 1'b0;
                if (bc_dec != '0)
                begin
                    if (bc_dec > rx) mosi_next = shifted[FRAME_W-1];
                end
                else
                begin
                    // close the frame
                    cs_next = 1'b1;
                    if (kind == F_READ || kind == F_RDSR) rdata_next = in_shift_reg;
                    if (kind == F_POLL && in_shift_reg[0] && poll_cnt_reg < cfg.poll_limit)
                    begin
                        poll_cnt_next = poll_cnt_reg + 8'd1;
                        load          = frame_load(F_POLL, addr_reg, data_reg,
                                                   cfg.status_preamble);
                        bit_cnt_next  = load[LOAD_W-1:FRAME_W];
                        shift_next    = load[FRAME_W-1:0];
                        in_shift_next = '0;
                    end
                    else
                    begin
                        if (kind == F_POLL && in_shift_reg[0]) tout_next = 1'b1;
                        next_kind = prog_kind(op_reg, step_inc);
                        if (next_kind == F_END)
                        begin
                            step_next = SEQ_IDLE;
                            done      = 1'b1;
                        end
                        else
                        begin
                            step_next = {1'b0, step_inc};
                            if (next_kind == F_POLL) poll_cnt_next = '0;
                            load          = frame_load(next_kind, addr_reg, data_reg,
                                                       cfg.status_preamble);
                            bit_cnt_next  = load[LOAD_W-1:FRAME_W];
                            shift_next    = load[FRAME_W-1:0];
                            in_shift_next = '0;
                        end
                    end
                end
            end
        end
        else
        begin
            hp_cnt_next = hp_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= SEQ_IDLE;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            in_shift_reg <= '0;
            hp_cnt_reg   <= '0;
            poll_cnt_reg <= '0;
            op_reg       <= OP_READ_BYTE;
            addr_reg     <= '0;
            data_reg     <= '0;
            sclk_reg     <= 1'b1;
            mosi_reg     <= 1'b1;
            cs_reg       <= 1'b1;
            rdata_reg    <= '0;
            tout_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            step_reg     <= step_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            in_shift_reg <= in_shift_next;
            hp_cnt_reg   <= hp_cnt_next;
            poll_cnt_reg <= poll_cnt_next;
            op_reg       <= op_next;
            addr_reg     <= addr_next;
            data_reg     <= data_next;
            sclk_reg     <= sclk_next;
            mosi_reg     <= mosi_next;
            cs_reg       <= cs_next;
            rdata_reg    <= rdata_next;
            tout_reg     <= tout_next;
        end
    end

    always_comb
    begin
        result.sclk      = sclk_next;
        result.mosi      = mosi_next;
        result.cs_n      = cs_next;
        result.busy_res  = (step_next != SEQ_IDLE);
        result.done_res  = done;
        result.read_data = rdata_next;
        result.timed_out = tout_next;
    end

endmodule

@@ design/spi_eeprom_master.sv @@
// ----------------------------------------------------------------------------
// SPI EEPROM master
// Mode-0 SPI master for a 25xx-style EEPROM, stepped one tick per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Each beat on the s_ group is one tick of the SPI engine: it carries the
//   start request, opcode, address, write byte and the sampled miso level.
//   Every accepted beat yields exactly one beat on the m_ group with the pin
//   levels (sclk, mosi, cs_n) after that tick plus busy, done, read data and
//   the poll timeout flag.
//   The result of a beat is registered at the edge that accepts it.
//   Throughput is one beat per cycle while s_tready is high; the tick update
//   is a single pass from the engine state registers into the result register.
//   The result register doubles as the hand-off stage: while it is full and
//   m_tready is low, s_tready drops and the engine state holds.
//   The cfg channel writes half_period, poll_limit and status_preamble by
//   index and is always ready; unknown indexes are dropped.
//   Reset returns the engine to idle with all pins high and the registers to
//   280 ticks per half bit, a poll limit of 255 and a preamble of 0x80.
// ----------------------------------------------------------------------------
module spi_eeprom_master #(
    parameter int ADDR_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // start_req, opcode[1:0], address[15:0],
                                   // write_data[7:0], miso, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sclk, mosi, cs_n, busy_res, done_res,
                                   // read_data[7:0], timed_out, zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sem_pkg::*;

    sem_cfg_t    cfg;
    sem_result_t result;
    sem_result_t res_reg;
    logic        res_valid_reg;
    logic        res_valid_next;
    logic        accept;

    assign cfg_ready      = 1'b1;
    assign s_tready       = !res_valid_reg || m_tready;
    assign accept         = s_tvalid && s_tready;
    assign res_valid_next = accept || (res_valid_reg && !m_tready);

    sem_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sem_engine #(
        .ADDR_BITS (ADDR_BITS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (accept),
        .cfg        (cfg),
        .start_req  (s_tdata[0]),
        .opcode     (s_tdata[2:1]),
        .address    (s_tdata[18:3]),
        .write_data (s_tdata[26:19]),
        .miso       (s_tdata[27]),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= result;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tdata  = {2'b00, res_reg};

endmodule
